>>> src/trmt_pkg.sv
`timescale 1ns / 1ps
package trmt_pkg;

  // quotient bits kept by the divider, t and s saturate at 2^62
  localparam int QBITS = 63;

  // stage counts of the parts of the pipeline
  localparam int FRONT_LAT = 4;
  localparam int MUL_LAT   = 3;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int TERM_LAT  = 2;
  localparam int LATENCY   = FRONT_LAT + MUL_LAT + 2 + DIV_LAT + TERM_LAT + 1;

  typedef enum logic [1:0] {
    STATUS_NORMAL   = 2'd0,
    STATUS_PARALLEL = 2'd1,
    STATUS_INVALID  = 2'd2
  } status_t;

  // register decode on paddr[2]
  localparam logic REG_PAR_THR = 1'b0;
  localparam logic REG_DIR_MIN = 1'b1;

  typedef struct packed {
    logic [2:0][31:0] l0;
    logic [2:0][31:0] u;
    logic [2:0][31:0] r0;
    logic [2:0][31:0] v;
  } side_t;

  typedef struct packed {
    logic inv;
    logic par;
    logic tneg;
    logic sneg;
  } flag_t;

endpackage

>>> src/trmt_mul64.sv
`timescale 1ns / 1ps
module trmt_mul64 (
  input  logic                 clk,
  input  logic signed [63:0]   x,
  input  logic signed [63:0]   y,
  output logic signed [127:0]  p
);

  logic [63:0]  xm;
  logic [63:0]  ym;
  logic         neg_a;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic         neg_b;
  logic [127:0] sum;

  // magnitudes
  always_ff @(posedge clk) begin
    xm    <= x[63] ? 64'(-x) : 64'(x);
    ym    <= y[63] ? 64'(-y) : 64'(y);
    neg_a <= x[63] ^ y[63];
  end

  // four 32x32 partial products
  always_ff @(posedge clk) begin
    p00   <= xm[31:0] * ym[31:0];
    p01   <= xm[31:0] * ym[63:32];
    p10   <= xm[63:32] * ym[31:0];
    p11   <= xm[63:32] * ym[63:32];
    neg_b <= neg_a;
  end

  always_comb begin
    sum = {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
  end

  always_ff @(posedge clk) begin
    p <= neg_b ? $signed(128'(~sum + 128'd1)) : $signed(sum);
  end

endmodule

>>> src/trmt_div.sv
`timescale 1ns / 1ps
module trmt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic [127:0]                num,
  input  logic [127:0]                den,
  output logic [trmt_pkg::QBITS-1:0]  quo
);

  localparam int QB = trmt_pkg::QBITS;
  localparam logic [QB-1:0] T_LIMIT = QB'(64'd1 << 62);

  logic [127:0]  rem  [0:QB-1];
  logic [127:0]  dv   [0:QB-1];
  logic [QB-1:0] bits [0:QB-1];
  logic [QB-1:0] q    [0:QB];
  logic          ovf  [0:QB];

  // entry: upper dividend bits, overflow when quotient would need more than QB bits
  always_ff @(posedge clk) begin
    rem[0]  <= num >> (QB - FRAC_BITS);
    dv[0]   <= den;
    bits[0] <= QB'(num[QB-1:0] << FRAC_BITS);
    ovf[0]  <= (num >> (QB - FRAC_BITS)) >= den;
    q[0]    <= '0;
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [128:0] trial;
    logic [129:0] diff;
    logic         ge;

    always_comb begin
      trial = {rem[k-1], bits[k-1][QB-1]};
      diff  = {1'b0, trial} - {2'b00, dv[k-1]};
      ge    = !diff[129];
    end

    always_ff @(posedge clk) begin
      q[k]   <= {q[k-1][QB-2:0], ge};
      ovf[k] <= ovf[k-1];
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k]  <= ge ? diff[127:0] : trial[127:0];
        dv[k]   <= dv[k-1];
        bits[k] <= bits[k-1] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo <= (ovf[QB] || (q[QB] > T_LIMIT)) ? T_LIMIT : q[QB];
  end

endmodule

>>> src/trmt_term.sv
`timescale 1ns / 1ps
module trmt_term #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic signed [31:0]          comp,
  input  logic [trmt_pkg::QBITS-1:0]  tmag,
  input  logic                        tneg,
  output logic signed [61:0]          term
);

  localparam logic [95:0] TERM_LIMIT = 96'd1 << 60;

  logic [31:0] cm;
  logic [63:0] plo;
  logic [62:0] phi;
  logic        neg;
  logic [95:0] prod;
  logic [95:0] sh;
  logic [60:0] mag;

  assign cm = comp[31] ? 32'(-comp) : 32'(comp);

  always_ff @(posedge clk) begin
    plo <= cm * tmag[31:0];
    phi <= cm * tmag[62:32];
    neg <= comp[31] ^ tneg;
  end

  always_comb begin
    prod = {32'd0, plo} + {1'b0, phi, 32'd0};
    sh   = prod >> FRAC_BITS;
    mag  = (sh > TERM_LIMIT) ? TERM_LIMIT[60:0] : sh[60:0];
  end

  always_ff @(posedge clk) begin
    term <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

>>> src/two_ray_midpoint_triangulator_top.sv
`timescale 1ns / 1ps
// two-ray midpoint triangulator
// takes two rays (start point and direction, signed fixed point with FRAC_BITS
// fraction bits) and gives the midpoint of their mutually closest points
// input: a word is taken at each rising edge where start is high and busy is
//   low; busy stays low, so a new ray pair can enter every cycle
// output: done is high for exactly one cycle with gaze_x/y/z and status;
//   the receiver cannot stall, so nothing ever waits inside the block
// pipeline: the dot-product, 64x64 multiply, determinant and magnitude stages,
//   then the 63-stage restoring divider, one quotient bit per stage, then the
//   term stages and the registered output
// throughput: one word per cycle
// status: normal, near parallel (start midpoint) or invalid direction (origin)
// config: apb-style port, parallel_threshold at 0x0, direction_min_sq at 0x4,
//   both reset to 1; write only while no word is in flight
// reset: synchronous, clears the valid line and done, restores the registers
module two_ray_midpoint_triangulator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] left_start_x,
  input  logic signed [31:0] left_start_y,
  input  logic signed [31:0] left_start_z,
  input  logic signed [31:0] left_dir_x,
  input  logic signed [31:0] left_dir_y,
  input  logic signed [31:0] left_dir_z,
  input  logic signed [31:0] right_start_x,
  input  logic signed [31:0] right_start_y,
  input  logic signed [31:0] right_start_z,
  input  logic signed [31:0] right_dir_x,
  input  logic signed [31:0] right_dir_y,
  input  logic signed [31:0] right_dir_z,
  output logic               done,
  output logic signed [31:0] gaze_x,
  output logic signed [31:0] gaze_y,
  output logic signed [31:0] gaze_z,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // stage numbers, counted in registers after the accepting edge
  localparam int ST_DOT  = trmt_pkg::FRONT_LAT;
  localparam int ST_FLAG = ST_DOT + 1;
  localparam int ST_MUL  = ST_DOT + trmt_pkg::MUL_LAT;
  localparam int ST_SUB  = ST_MUL + 1;
  localparam int ST_ABS  = ST_SUB + 1;
  localparam int ST_DIV  = ST_ABS + trmt_pkg::DIV_LAT;
  localparam int ST_TERM = ST_DIV + trmt_pkg::TERM_LAT;

  // ---------------- configuration registers ----------------
  logic [15:0] par_thr;
  logic [15:0] dir_min;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      par_thr <= 16'd1;
      dir_min <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        trmt_pkg::REG_PAR_THR: par_thr <= pwdata[15:0];
        trmt_pkg::REG_DIR_MIN: dir_min <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      trmt_pkg::REG_PAR_THR: prdata = {16'd0, par_thr};
      trmt_pkg::REG_DIR_MIN: prdata = {16'd0, dir_min};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------- valid line and side data ----------------
  // no back-pressure anywhere, so every stage advances each cycle
  assign busy = 1'b0;

  logic [ST_TERM:1]      vld;
  trmt_pkg::side_t       side_line [1:ST_TERM];
  trmt_pkg::flag_t       flg       [ST_FLAG:ST_TERM];
  trmt_pkg::flag_t       flg_abs;
  logic                  inv_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST_TERM-1:1], start & ~busy};
    end
  end

  // start points and directions ride along until the final sum
  always_ff @(posedge clk) begin
    side_line[1].l0 <= {left_start_z, left_start_y, left_start_x};
    side_line[1].u  <= {left_dir_z, left_dir_y, left_dir_x};
    side_line[1].r0 <= {right_start_z, right_start_y, right_start_x};
    side_line[1].v  <= {right_dir_z, right_dir_y, right_dir_x};
    for (int k = 2; k <= ST_TERM; k++) begin
      side_line[k] <= side_line[k-1];
    end
  end

  // ---------------- stage 2: w = R0 - L0, magnitudes ----------------
  logic [2:0][31:0] um;
  logic [2:0][31:0] vm;
  logic [2:0][32:0] wm;
  logic [2:0]       us;
  logic [2:0]       vs;
  logic [2:0]       ws;
  logic signed [32:0] w_c [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_c[i] = $signed({side_line[1].r0[i][31], side_line[1].r0[i]})
             - $signed({side_line[1].l0[i][31], side_line[1].l0[i]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      um[i] <= side_line[1].u[i][31] ? 32'(-$signed(side_line[1].u[i]))
                                     : side_line[1].u[i];
      vm[i] <= side_line[1].v[i][31] ? 32'(-$signed(side_line[1].v[i]))
                                     : side_line[1].v[i];
      wm[i] <= w_c[i][32] ? 33'(-w_c[i]) : 33'(w_c[i]);
      us[i] <= side_line[1].u[i][31];
      vs[i] <= side_line[1].v[i][31];
      ws[i] <= w_c[i][32];
    end
  end

  // ---------------- stage 3: per-axis products ----------------
  logic [2:0][63:0] pa;
  logic [2:0][63:0] pb;
  logic [2:0][63:0] pc;
  logic [2:0][64:0] pd;
  logic [2:0][64:0] pe;
  logic [2:0]       nb;
  logic [2:0]       nd;
  logic [2:0]       ne;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa[i] <= um[i] * um[i];
      pb[i] <= um[i] * vm[i];
      pc[i] <= vm[i] * vm[i];
      pd[i] <= um[i] * wm[i];
      pe[i] <= vm[i] * wm[i];
      nb[i] <= us[i] ^ vs[i];
      nd[i] <= us[i] ^ ws[i];
      ne[i] <= vs[i] ^ ws[i];
    end
  end

  // ---------------- stage 4: dot products a..e ----------------
  // each term truncated toward zero before its sign is applied
  logic signed [63:0] dot_a;
  logic signed [63:0] dot_b;
  logic signed [63:0] dot_c;
  logic signed [63:0] dot_d;
  logic signed [63:0] dot_e;
  logic signed [63:0] sa;
  logic signed [63:0] sb;
  logic signed [63:0] sc;
  logic signed [63:0] sd;
  logic signed [63:0] se;

  always_comb begin
    sa = '0;
    sb = '0;
    sc = '0;
    sd = '0;
    se = '0;
    for (int i = 0; i < 3; i++) begin
      sa = sa + $signed(64'(pa[i] >> FRAC_BITS));
      sc = sc + $signed(64'(pc[i] >> FRAC_BITS));
      sb = nb[i] ? sb - $signed(64'(pb[i] >> FRAC_BITS))
                 : sb + $signed(64'(pb[i] >> FRAC_BITS));
      sd = nd[i] ? sd - $signed(64'(pd[i] >> FRAC_BITS))
                 : sd + $signed(64'(pd[i] >> FRAC_BITS));
      se = ne[i] ? se - $signed(64'(pe[i] >> FRAC_BITS))
                 : se + $signed(64'(pe[i] >> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    dot_a <= sa;
    dot_b <= sb;
    dot_c <= sc;
    dot_d <= sd;
    dot_e <= se;
  end

  // invalid direction: squared length below the configured floor
  assign inv_c = (dot_a < $signed(64'(dir_min))) || (dot_c < $signed(64'(dir_min)));

  // ---------------- stages 5-7: exact 128-bit products ----------------
  logic signed [127:0] p_ac;
  logic signed [127:0] p_bb;
  logic signed [127:0] p_cd;
  logic signed [127:0] p_be;
  logic signed [127:0] p_bd;
  logic signed [127:0] p_ae;

  trmt_mul64 u_mul_ac (.clk(clk), .x(dot_a), .y(dot_c), .p(p_ac));
  trmt_mul64 u_mul_bb (.clk(clk), .x(dot_b), .y(dot_b), .p(p_bb));
  trmt_mul64 u_mul_cd (.clk(clk), .x(dot_c), .y(dot_d), .p(p_cd));
  trmt_mul64 u_mul_be (.clk(clk), .x(dot_b), .y(dot_e), .p(p_be));
  trmt_mul64 u_mul_bd (.clk(clk), .x(dot_b), .y(dot_d), .p(p_bd));
  trmt_mul64 u_mul_ae (.clk(clk), .x(dot_a), .y(dot_e), .p(p_ae));

  // ---------------- stage 8: determinant and numerators ----------------
  logic signed [127:0] den;
  logic signed [127:0] nt;
  logic signed [127:0] ns;

  always_ff @(posedge clk) begin
    den <= p_ac - p_bb;
    nt  <= p_cd - p_be;
    ns  <= p_bd - p_ae;
  end

  // ---------------- stage 9: magnitudes, parallel test ----------------
  logic [127:0] dm_c;
  logic [127:0] thr_c;
  logic [127:0] dm;
  logic [127:0] ntm;
  logic [127:0] nsm;

  always_comb begin
    dm_c  = den[127] ? 128'(-den) : 128'(den);
    thr_c = 128'(par_thr) << FRAC_BITS;
    flg_abs.inv  = flg[ST_ABS-1].inv;
    flg_abs.par  = (dm_c == 128'd0) || (dm_c < thr_c);
    flg_abs.tneg = nt[127] ^ den[127];
    flg_abs.sneg = ns[127] ^ den[127];
  end

  always_ff @(posedge clk) begin
    dm  <= dm_c;
    ntm <= nt[127] ? 128'(-nt) : 128'(nt);
    nsm <= ns[127] ? 128'(-ns) : 128'(ns);
  end

  // status flags follow the word from the dot stage to the output
  always_ff @(posedge clk) begin
    flg[ST_FLAG] <= '{inv: inv_c, par: 1'b0, tneg: 1'b0, sneg: 1'b0};
    for (int k = ST_FLAG + 1; k <= ST_TERM; k++) begin
      if (k == ST_ABS) begin
        flg[k] <= flg_abs;
      end else begin
        flg[k] <= flg[k-1];
      end
    end
  end

  // ---------------- divider: |t|, |s| in Q.FRAC_BITS ----------------
  logic [trmt_pkg::QBITS-1:0] tmag;
  logic [trmt_pkg::QBITS-1:0] smag;

  trmt_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (.clk(clk), .num(ntm), .den(dm), .quo(tmag));
  trmt_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (.clk(clk), .num(nsm), .den(dm), .quo(smag));

  // ---------------- term stages: u*t and v*s per axis ----------------
  logic signed [61:0] tu [0:2];
  logic signed [61:0] tv [0:2];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    trmt_term #(.FRAC_BITS(FRAC_BITS)) u_term_u (
      .clk  (clk),
      .comp ($signed(side_line[ST_DIV].u[i])),
      .tmag (tmag),
      .tneg (flg[ST_DIV].tneg),
      .term (tu[i])
    );
    trmt_term #(.FRAC_BITS(FRAC_BITS)) u_term_v (
      .clk  (clk),
      .comp ($signed(side_line[ST_DIV].v[i])),
      .tmag (smag),
      .tneg (flg[ST_DIV].sneg),
      .term (tv[i])
    );
  end

  // ---------------- output stage ----------------
  function automatic logic [31:0] sat32(input logic signed [63:0] val);
    logic [31:0] r;
    if (val > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (val < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = val[31:0];
    end
    return r;
  endfunction

  logic [31:0]        res_c [0:2];
  logic signed [63:0] sum_n;
  logic signed [63:0] sum_p;
  logic signed [31:0] l0_c;
  logic signed [31:0] r0_c;
  trmt_pkg::status_t  st_c;

  always_comb begin
    sum_n = '0;
    sum_p = '0;
    l0_c  = '0;
    r0_c  = '0;
    for (int i = 0; i < 3; i++) begin
      l0_c  = $signed(side_line[ST_TERM].l0[i]);
      r0_c  = $signed(side_line[ST_TERM].r0[i]);
      sum_p = 64'(l0_c) + 64'(r0_c);
      sum_n = 64'(l0_c) + 64'(r0_c) + 64'(tu[i]) + 64'(tv[i]);
      // halving rounds toward minus infinity
      if (flg[ST_TERM].inv) begin
        res_c[i] = 32'd0;
      end else if (flg[ST_TERM].par) begin
        res_c[i] = sat32(sum_p >>> 1);
      end else begin
        res_c[i] = sat32(sum_n >>> 1);
      end
    end
    if (flg[ST_TERM].inv) begin
      st_c = trmt_pkg::STATUS_INVALID;
    end else if (flg[ST_TERM].par) begin
      st_c = trmt_pkg::STATUS_PARALLEL;
    end else begin
      st_c = trmt_pkg::STATUS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[ST_TERM];
    end
  end

  always_ff @(posedge clk) begin
    gaze_x <= $signed(res_c[0]);
    gaze_y <= $signed(res_c[1]);
    gaze_z <= $signed(res_c[2]);
    status <= st_c;
  end

endmodule

>>> src/trmt_chk.sv
`timescale 1ns / 1ps
module trmt_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] gaze_x,
  input logic signed [31:0] gaze_y,
  input logic signed [31:0] gaze_z,
  input logic [1:0]         status,
  input logic               pready
);

  // every result traces back to a word taken a fixed latency earlier
  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, trmt_pkg::LATENCY))
    else $error("result without matching word");

  // invalid direction always reports the origin
  a_invalid_origin: assert property (@(posedge clk) disable iff (rst)
    (done && status == trmt_pkg::STATUS_INVALID) |->
      (gaze_x == 32'sd0 && gaze_y == 32'sd0 && gaze_z == 32'sd0))
    else $error("invalid status with nonzero point");

  // status is one of the three reported codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == trmt_pkg::STATUS_NORMAL || status == trmt_pkg::STATUS_PARALLEL
              || status == trmt_pkg::STATUS_INVALID))
    else $error("unknown status code");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind two_ray_midpoint_triangulator_top trmt_chk u_trmt_chk (.*);
